// ----- design/lud_pkg.sv -----
// ----------------------------------------------------------------------------
// LU decomposition package
// Shared constants, types and controller-to-datapath command/status structs.
// ----------------------------------------------------------------------------
package lud_pkg;

  localparam int MAX_ORDER     = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int FRAC_BITS     = ELEMENT_WIDTH / 2;
  localparam int IDX_W         = $clog2(MAX_ORDER);
  localparam int ADDR_W        = 2 * IDX_W;
  localparam int ORDER_W       = 7;
  localparam int QW            = ELEMENT_WIDTH + FRAC_BITS;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(MAX_ORDER);

  // datapath micro operations
  typedef enum logic [3:0] {
    DP_NOP  = 4'b0001,
    DP_LDP  = 4'b0010,  // latch pivot from read data
    DP_DIV  = 4'b0100,  // start divide of a(i,k) by pivot
    DP_UPD  = 4'b1000   // a(i,j) -= m * a(k,j)
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [ADDR_W-1:0]   rd_addr;
    logic                clr_flags;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic upd_done;
  } dp_stat_t;

  function automatic elem_t sat_elem(input logic signed [QW+ELEMENT_WIDTH:0] v,
                                     output logic sat);
    logic signed [QW+ELEMENT_WIDTH:0] mx;
    logic signed [QW+ELEMENT_WIDTH:0] mn;
    mx = (QW+ELEMENT_WIDTH+1)'({1'b0, {(ELEMENT_WIDTH-1){1'b1}}});
    mn = -mx - 1;
    sat = 1'b0;
    if (v > mx) begin
      sat = 1'b1;
      return elem_t'(mx);
    end
    if (v < mn) begin
      sat = 1'b1;
      return elem_t'(mn);
    end
    return elem_t'(v);
  endfunction

endpackage

// ----- design/lu_decomposition_in_place.sv -----
// ----------------------------------------------------------------------------
// In-place LU decomposition (Doolittle, no pivoting), Q16.16
// Command-driven matrix store with a sequenced elimination engine.
// ----------------------------------------------------------------------------
// Usage: issue a request with start high while busy is low. in_opcode selects
// write element (no result), start decomposition, or read element.
// A write stores in_element_in at (in_row_index, in_column_index). A read
// returns the element through the memory read register and a hold register,
// with out_strobe high for one cycle and out_result_kind 0.
// Start factors the leading cfg order block in place; busy stays high for
// the whole elimination. Each multiplier takes a serial 48-step restoring
// divide (skipped on a zero pivot) and each update passes a three-stage
// multiply and subtract pipeline; all writes share the single memory write
// port, and every divide uses the shared divider. The finished
// result has out_result_kind 1; flags are reported with every result.
// out_ results cannot be held off; the receiver must take them when strobed.
// Reset sets the order to 64 and clears flags; matrix contents are undefined.
// ----------------------------------------------------------------------------
module lu_decomposition_in_place (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  logic [5:0]            in_row_index,
  input  logic [5:0]            in_column_index,
  input  logic signed [31:0]    in_element_in,
  output logic                  out_strobe,
  output logic                  out_result_kind,
  output logic signed [31:0]    out_element_out,
  output logic                  out_zero_pivot,
  output logic                  out_overflowed,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata
);
  logic [lud_pkg::ORDER_W-1:0] order_r;
  lud_pkg::dp_cmd_t  ctl_cmd, cmd;
  lud_pkg::dp_stat_t stat;
  logic [lud_pkg::ADDR_W-1:0] ctl_tgt;
  logic active, done;
  lud_pkg::elem_t rd_data;
  logic zp, ov;
  logic acc;
  logic rd1_r, rd2_r, done1_r;

  assign acc  = start && !busy;
  assign busy = active || done || done1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= lud_pkg::ORDER_RESET;
      rd1_r   <= 1'b0;
      rd2_r   <= 1'b0;
      done1_r <= 1'b0;
    end else begin
      if (cfg_we) order_r <= cfg_wdata;
      rd1_r   <= acc && (in_opcode == lud_pkg::OP_READ);
      rd2_r   <= rd1_r;
      done1_r <= done;
    end
  end

  always_comb begin
    cmd = ctl_cmd;
    if (!active) cmd.rd_addr = {in_row_index, in_column_index};
  end

  lud_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (acc && (in_opcode == lud_pkg::OP_START)),
    .order    (order_r),
    .stat     (stat),
    .cmd      (ctl_cmd),
    .tgt_addr (ctl_tgt),
    .active   (active),
    .done     (done)
  );

  lud_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .ext_we     (acc && (in_opcode == lud_pkg::OP_WRITE)),
    .ext_waddr  ({in_row_index, in_column_index}),
    .ext_wdata  (in_element_in),
    .tgt_addr   (ctl_tgt),
    .rd_data    (rd_data),
    .zero_pivot (zp),
    .overflowed (ov)
  );

  // read data is registered once in memory, once more here; hold the flags
  // seen at the read so a start right behind it cannot clear them early
  logic signed [31:0] rd_hold_r;
  logic               rd_zp_r, rd_ov_r;
  always_ff @(posedge clk) begin
    rd_hold_r <= rd_data;
    rd_zp_r   <= zp;
    rd_ov_r   <= ov;
  end

  assign out_strobe      = rd2_r || done1_r;
  assign out_result_kind = done1_r;
  assign out_element_out = done1_r ? '0 : rd_hold_r;
  assign out_zero_pivot  = done1_r ? zp : rd_zp_r;
  assign out_overflowed  = done1_r ? ov : rd_ov_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd2_r && done1_r)) else $error("read and done results collide");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy) else $error("done without busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_opcode == lud_pkg::OP_START) |=> busy)
    else $error("start did not raise busy");

endmodule

// ----- design/lud_datapath.sv -----
// ----------------------------------------------------------------------------
// LU datapath
// Matrix memory, serial restoring divider and multiply/subtract pipeline.
// ----------------------------------------------------------------------------
module lud_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lud_pkg::dp_cmd_t                cmd,
  output lud_pkg::dp_stat_t               stat,
  // external element write
  input  logic                            ext_we,
  input  logic [lud_pkg::ADDR_W-1:0]      ext_waddr,
  input  lud_pkg::elem_t                  ext_wdata,
  // upd step addresses: target a(i,j), row operand address a(k,j) already read
  input  logic [lud_pkg::ADDR_W-1:0]      tgt_addr,
  output lud_pkg::elem_t                  rd_data,
  output logic                            zero_pivot,
  output logic                            overflowed
);
  localparam int W  = lud_pkg::ELEMENT_WIDTH;
  localparam int QW = lud_pkg::QW;
  localparam int CW = $clog2(QW + 1);
  localparam int BW = QW + W + 1;

  lud_pkg::elem_t mem [lud_pkg::MAX_ORDER*lud_pkg::MAX_ORDER];
  lud_pkg::elem_t rd_data_r;

  lud_pkg::elem_t pivot_r;
  lud_pkg::elem_t mult_r;
  logic           zp_r, ov_r;

  // divider
  logic           div_busy_r;
  logic [CW-1:0]  div_cnt_r;
  logic [QW-1:0]  quo_r;
  logic [W:0]     rem_r;
  logic [QW-1:0]  dvd_r;
  logic [W-1:0]   dsr_r;
  logic           qneg_r;
  logic           div_done_r;
  logic [lud_pkg::ADDR_W-1:0] div_addr_r;

  // update pipeline: stage 1 waits target read, stage 2 product, stage 3 write
  logic                          u1_r, u2_r, u3_r;
  logic [lud_pkg::ADDR_W-1:0]    a1_r, a2_r, a3_r;
  lud_pkg::elem_t                row_r;
  logic signed [2*W-1:0]         prod_r;
  lud_pkg::elem_t                tgt_r, tgt3_r;
  lud_pkg::elem_t                res_r;
  logic                          psat_r;

  // second memory read port for target
  lud_pkg::elem_t tgt_rd_r;

  logic           mwe;
  logic [lud_pkg::ADDR_W-1:0] mwa;
  lud_pkg::elem_t mwd;

  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    rd_data_r <= mem[cmd.rd_addr];
    tgt_rd_r  <= mem[tgt_addr];
  end

  assign rd_data = rd_data_r;

  // divide setup from read data
  logic [W-1:0] abs_a, abs_b;
  assign abs_a = rd_data_r[W-1] ? W'(-rd_data_r) : rd_data_r;
  assign abs_b = pivot_r[W-1] ? W'(-pivot_r) : pivot_r;

  logic [W:0] rem_sh;
  logic [W:0] rem_sub;
  assign rem_sh  = {rem_r[W-1:0], dvd_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  logic signed [BW-1:0] q_ext;
  lud_pkg::elem_t       q_sat;
  logic                 q_ov;
  always_comb begin
    q_ext = qneg_r ? -BW'(quo_r) : BW'(quo_r);
    q_sat = lud_pkg::sat_elem(q_ext, q_ov);
  end

  logic signed [BW-1:0] p_ext;
  lud_pkg::elem_t       p_sat;
  logic                 p_ov;
  logic signed [BW-1:0] d_ext;
  lud_pkg::elem_t       d_sat;
  logic                 d_ov;
  always_comb begin
    // truncate toward zero: bias negatives before the shift
    p_ext = BW'((prod_r + (prod_r[2*W-1] ? (2*W)'((1 << lud_pkg::FRAC_BITS) - 1)
                                          : (2*W)'(0))) >>> lud_pkg::FRAC_BITS);
    p_sat = lud_pkg::sat_elem(p_ext, p_ov);
    d_ext = BW'(tgt3_r) - BW'(res_r);
    d_sat = lud_pkg::sat_elem(d_ext, d_ov);
  end

  always_comb begin
    mwe = 1'b0;
    mwa = ext_waddr;
    mwd = ext_wdata;
    if (ext_we) begin
      mwe = 1'b1;
    end else if (div_done_r) begin
      mwe = 1'b1;
      mwa = div_addr_r;
      mwd = mult_r;
    end else if (u3_r) begin
      mwe = 1'b1;
      mwa = a3_r;
      mwd = d_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zp_r <= 1'b0;
      ov_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
      u1_r <= 1'b0;
      u2_r <= 1'b0;
      u3_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      u1_r <= 1'b0;
      u2_r <= u1_r;
      u3_r <= u2_r;
      if (cmd.clr_flags) begin
        zp_r <= 1'b0;
        ov_r <= 1'b0;
      end
      if (cmd.op == lud_pkg::DP_LDP) pivot_r <= rd_data_r;
      if (cmd.op == lud_pkg::DP_DIV) begin
        div_addr_r <= tgt_addr;
        if (pivot_r == '0) begin
          zp_r <= 1'b1;
          mult_r <= (rd_data_r == '0) ? '0 :
                    rd_data_r[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          div_done_r <= 1'b1;
        end else begin
          div_busy_r <= 1'b1;
          div_cnt_r  <= CW'(QW);
          dvd_r      <= {abs_a, {lud_pkg::FRAC_BITS{1'b0}}};
          dsr_r      <= abs_b;
          rem_r      <= '0;
          quo_r      <= '0;
          qneg_r     <= rd_data_r[W-1] ^ pivot_r[W-1];
        end
      end
      if (div_busy_r) begin
        if (div_cnt_r == '0) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
          mult_r     <= q_sat;
          if (q_ov) ov_r <= 1'b1;
        end else begin
          div_cnt_r <= div_cnt_r - CW'(1);
          dvd_r     <= {dvd_r[QW-2:0], 1'b0};
          if (!rem_sub[W]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
        end
      end
      if (cmd.op == lud_pkg::DP_UPD) begin
        u1_r  <= 1'b1;
        a1_r  <= tgt_addr;
        row_r <= rd_data_r;
      end
      if (u1_r) begin
        a2_r   <= a1_r;
        prod_r <= mult_r * row_r;
        tgt_r  <= tgt_rd_r;
      end
      if (u2_r) begin
        a3_r   <= a2_r;
        res_r  <= p_sat;
        tgt3_r <= tgt_r;
        psat_r <= p_ov;
      end
      if (u3_r && (d_ov || psat_r)) ov_r <= 1'b1;
    end
  end

  assign stat.div_done = div_done_r;
  assign stat.upd_done = u3_r;
  assign zero_pivot = zp_r;
  assign overflowed = ov_r;

endmodule

// ----- design/lud_ctrl.sv -----
// ----------------------------------------------------------------------------
// LU controller
// Sequences the k/i/j elimination loops one step at a time.
// ----------------------------------------------------------------------------
module lud_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [lud_pkg::ORDER_W-1:0]     order,
  input  lud_pkg::dp_stat_t               stat,
  output lud_pkg::dp_cmd_t                cmd,
  output logic [lud_pkg::ADDR_W-1:0]      tgt_addr,
  output logic                            active,
  output logic                            done
);
  localparam int IW = lud_pkg::IDX_W;
  localparam logic [IW:0] ONE = (IW+1)'(1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRD   = 7'b0000010,  // read pivot
    S_PLD   = 7'b0000100,  // latch pivot
    S_ARD   = 7'b0001000,  // read a(i,k)
    S_DIV   = 7'b0010000,  // divide, wait for quotient
    S_UPD   = 7'b0100000,  // issue row updates
    S_DRAIN = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [IW:0] n_r, k_r, i_r, j_r;
  logic [IW:0] n_nxt, k_nxt, i_nxt, j_nxt;
  logic        issued_r, issued_nxt;
  logic        done_r, done_nxt;

  function automatic logic [lud_pkg::ADDR_W-1:0] addr(input logic [IW:0] r,
                                                      input logic [IW:0] c);
    return {r[IW-1:0], c[IW-1:0]};
  endfunction

  always_comb begin
    state_nxt  = state_r;
    n_nxt = n_r; k_nxt = k_r; i_nxt = i_r; j_nxt = j_r;
    issued_nxt = 1'b0;
    done_nxt   = 1'b0;
    cmd.op        = lud_pkg::DP_NOP;
    cmd.rd_addr   = addr(k_r, k_r);
    cmd.clr_flags = 1'b0;
    tgt_addr      = addr(i_r, k_r);
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          cmd.clr_flags = 1'b1;
          n_nxt = (order > lud_pkg::ORDER_W'(lud_pkg::MAX_ORDER)) ?
                  (IW+1)'(lud_pkg::MAX_ORDER) : (IW+1)'(order);
          k_nxt = '0;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        if (k_r + ONE >= n_r) begin
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          i_nxt = k_r + ONE;
          state_nxt = S_PLD;
        end
      end
      S_PLD: begin
        cmd.op = lud_pkg::DP_LDP;
        cmd.rd_addr = addr(i_r, k_r);
        state_nxt = S_ARD;
      end
      S_ARD: begin
        cmd.rd_addr = addr(i_r, k_r);
        cmd.op = lud_pkg::DP_DIV;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          j_nxt = k_r + ONE;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // read a(k,j) now, issue update next cycle with it
        cmd.rd_addr = addr(k_r, j_r);
        tgt_addr    = addr(i_r, j_r - ONE);
        if (issued_r) cmd.op = lud_pkg::DP_UPD;
        if (j_r < n_r) begin
          j_nxt = j_r + ONE;
          issued_nxt = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait while an update write sits in stage 3, pipeline is 3 deep
        if (!stat.upd_done && !issued_r) begin
          j_nxt = '0;
          if (i_r + ONE < n_r) begin
            i_nxt = i_r + ONE;
            state_nxt = S_PLD;
          end else begin
            k_nxt = k_r + ONE;
            state_nxt = S_PRD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      done_r   <= done_nxt;
    end
    n_r <= n_nxt; k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt;
  end

  assign active = (state_r != S_IDLE);
  assign done   = done_r;

endmodule
